/* hdl/sefr_pkg.sv */
`default_nettype none

package sefr_pkg;

  localparam int MAX_FRAME = 256;
  // position field is 8 bits, so a frame never runs past 256 bytes
  localparam int FRAME_LIM = (MAX_FRAME < 256) ? MAX_FRAME : 256;
  localparam int MIN_FRAME = 3;

  localparam int CNT_W = 9;

  typedef enum logic [1:0] {
    REG_START_CODE = 2'd0,
    REG_END_CODE   = 2'd1,
    REG_OK_FLAG    = 2'd2,
    REG_MAX_LENGTH = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_FLAG  = 3'd1,
    ST_LRC_ERR   = 3'd2,
    ST_READ_FAIL = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'b001,
    PH_BODY  = 3'b010,
    PH_CHECK = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0]       start_code;
    logic [7:0]       end_code;
    logic [7:0]       ok_flag;
    logic [CNT_W-1:0] max_length;
  } cfg_t;

  typedef struct packed {
    phase_t           phase;
    logic [7:0]       lrc;
    logic [CNT_W-1:0] count;
    logic             flag_matched;
  } frame_st_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic [7:0] position;
    logic       last;
    status_t    status;
  } result_t;

  localparam frame_st_t FRAME_CLEAR = '{
    phase: PH_HUNT, lrc: 8'd0, count: '0, flag_matched: 1'b0
  };

  function automatic logic [CNT_W-1:0] eff_max(input logic [CNT_W-1:0] m);
    logic [CNT_W-1:0] r;
    r = m;
    if (r < CNT_W'(MIN_FRAME)) r = CNT_W'(MIN_FRAME);
    if (r > CNT_W'(FRAME_LIM)) r = CNT_W'(FRAME_LIM);
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/sefr_core.sv */
`default_nettype none

module sefr_core (
  input  sefr_pkg::cfg_t      cfg,
  input  sefr_pkg::frame_st_t st,
  input  logic [7:0]          rx_byte,
  input  logic                line_error,
  output sefr_pkg::frame_st_t st_nxt,
  output sefr_pkg::result_t   res
);
  import sefr_pkg::*;

  logic [CNT_W-1:0] lim;
  logic             flag_ok;
  logic             is_pos1;

  assign lim     = eff_max(cfg.max_length);
  assign is_pos1 = (st.count == CNT_W'(1));
  assign flag_ok = is_pos1 ? (rx_byte == cfg.ok_flag) : st.flag_matched;

  always_comb begin
    st_nxt       = st;
    res.emit     = 1'b0;
    res.data     = rx_byte;
    res.position = st.count[7:0];
    res.last     = 1'b0;
    res.status   = ST_OK;

    if (line_error) begin
      st_nxt       = FRAME_CLEAR;
      res.emit     = 1'b1;
      res.data     = 8'd0;
      res.position = 8'd0;
      res.last     = 1'b1;
      res.status   = ST_READ_FAIL;
    end else begin
      case (st.phase)
        PH_BODY, PH_CHECK: begin
          res.emit = 1'b1;
          if (st.count >= lim) begin
            st_nxt     = FRAME_CLEAR;
            res.last   = 1'b1;
            res.status = ST_OVERFLOW;
          end else if (st.phase == PH_BODY) begin
            st_nxt.lrc   = st.lrc ^ rx_byte;
            st_nxt.count = st.count + CNT_W'(1);
            if (is_pos1) st_nxt.flag_matched = (rx_byte == cfg.ok_flag);
            if (rx_byte == cfg.end_code) st_nxt.phase = PH_CHECK;
          end else begin
            // check byte closes the frame; bad flag wins over lrc mismatch
            st_nxt   = FRAME_CLEAR;
            res.last = 1'b1;
            if (!flag_ok)              res.status = ST_BAD_FLAG;
            else if (rx_byte != st.lrc) res.status = ST_LRC_ERR;
            else                       res.status = ST_OK;
          end
        end
        default: begin
          // hunting: drop everything but the start code
          st_nxt.phase = PH_HUNT;
          if (rx_byte == cfg.start_code) begin
            res.emit            = 1'b1;
            res.position        = 8'd0;
            st_nxt.lrc          = 8'd0;
            st_nxt.flag_matched = 1'b0;
            st_nxt.count        = CNT_W'(1);
            st_nxt.phase        = (rx_byte == cfg.end_code) ? PH_CHECK : PH_BODY;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/stx_etx_frame_receiver_lrc.sv */
`default_nettype none

// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | in_rx_byte, in_line_error
// out     | output    | out_valid / out_ready | out_byte, out_position, out_last, out_status
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one request per cycle sustained while out_ready stays high; a request is held in the
// input register, then its result in the result register after one pass of frame logic
// bytes dropped while hunting give no result; cfg_ready is always high
// rst_n (synchronous) restores register defaults and returns to hunting
// a stalled result holds the result register; the input register then fills
// and in_ready drops only when both are occupied

module stx_etx_frame_receiver_lrc (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       in_line_error,

  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [7:0] out_position,
  output logic       out_last,
  output logic [2:0] out_status,

  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);
  import sefr_pkg::*;

  cfg_t      cfg_r;
  frame_st_t st_r;
  frame_st_t st_nxt;
  result_t   res;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_err_r;
  logic       s1_fire;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [7:0] out_byte_r;
  logic [7:0] out_pos_r;
  logic       out_last_r;
  status_t    out_status_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{start_code: 8'd2, end_code: 8'd3, ok_flag: 8'd0,
                 max_length: CNT_W'(256)};
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_START_CODE: cfg_r.start_code <= cfg_data[7:0];
        REG_END_CODE:   cfg_r.end_code   <= cfg_data[7:0];
        REG_OK_FLAG:    cfg_r.ok_flag    <= cfg_data[7:0];
        REG_MAX_LENGTH: cfg_r.max_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register moves on when the result register is free or draining
  assign s1_fire       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready      = !s1_valid_r || s1_fire;
  assign out_valid_nxt = s1_fire ? res.emit : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
      s1_err_r  <= in_line_error;
    end
  end

  sefr_core u_core (
    .cfg        (cfg_r),
    .st         (st_r),
    .rx_byte    (s1_byte_r),
    .line_error (s1_err_r),
    .st_nxt     (st_nxt),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= FRAME_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s1_fire) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res.emit) begin
      out_byte_r   <= res.data;
      out_pos_r    <= res.position;
      out_last_r   <= res.last;
      out_status_r <= res.status;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_position = out_pos_r;
  assign out_last     = out_last_r;
  assign out_status   = out_status_r;

endmodule

`default_nettype wire

/* hdl/sefr_checker.sv */
`default_nettype none

module sefr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [7:0] out_position,
  input logic       out_last,
  input logic [2:0] out_status
);
  import sefr_pkg::*;

  // status only means something on the closing result
  a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == ST_OK)
    else $error("status set on a result that is not last");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_BAD_FLAG ||
                   out_status == ST_LRC_ERR || out_status == ST_READ_FAIL ||
                   out_status == ST_OVERFLOW))
    else $error("unknown status code");

  a_read_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_READ_FAIL |-> out_last && out_byte == 8'd0 &&
                                                out_position == 8'd0)
    else $error("read failure result malformed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
                                $stable(out_position) && $stable(out_last) &&
                                $stable(out_status))
    else $error("stalled result changed");

endmodule

bind stx_etx_frame_receiver_lrc sefr_checker u_sefr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_byte     (out_byte),
  .out_position (out_position),
  .out_last     (out_last),
  .out_status   (out_status)
);

`default_nettype wire
